// ----- src/crpe_pkg.sv -----
`default_nettype none
package crpe_pkg;

    localparam int MaxPointsDefault = 64;
    localparam int TFracBitsDefault = 16;
    localparam int CoordW = 32;
    localparam int CfgAddrW = 3;

    localparam logic CmdLoad = 1'b0;
    localparam logic CmdEval = 1'b1;

    localparam logic [CfgAddrW-1:0] RegNumPoints = 3'd0;
    localparam logic [6:0] NumPointsReset = 7'd4;

endpackage
`default_nettype wire

// ----- src/crpe_front.sv -----
`default_nettype none
// Front part: clamps the point count and t, splits t into a segment and a
// fraction, and packs loads and evaluations alike into queue words so that the
// back part sees them in their original order.
module crpe_front #(
    parameter int MAX_POINTS  = crpe_pkg::MaxPointsDefault,
    parameter int T_FRAC_BITS = crpe_pkg::TFracBitsDefault,
    parameter int IDX_W       = $clog2(MAX_POINTS)
) (
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   in_cmd,
    input  wire logic [5:0]             in_index,
    input  wire logic [95:0]            in_coords,
    input  wire logic [T_FRAC_BITS:0]   in_t,
    input  wire logic [6:0]             num_points,
    // Classified word towards the queue: i0, i1, i2, i3, u, eval flag,
    // load flag, load slot, load coordinates from the lowest bit up.
    output logic                        q_valid,
    input  wire logic                   q_ready,
    output logic [5*IDX_W+T_FRAC_BITS+98:0] q_data
);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = T_FRAC_BITS + 1 + NW;

    logic [NW-1:0]          n_c;
    logic [T_FRAC_BITS:0]   t_c;
    logic [SW-1:0]          s_c;
    logic [NW-1:0]          seg_c;
    logic [T_FRAC_BITS:0]   u_c;
    logic [IDX_W-1:0]       i0, i1, i2, i3;
    logic [6:0]             n7;
    logic                   ld_c, ev_c;

    assign in_ready = q_ready;
    // A load aimed beyond the table travels as an empty word.
    assign ld_c = (in_cmd == crpe_pkg::CmdLoad) && ({26'd0, in_index} < MAX_POINTS);
    assign ev_c = (in_cmd == crpe_pkg::CmdEval);

    always_comb begin
        // Point count clamp.
        n7 = num_points;
        if (n7 < 7'd4) n7 = 7'd4;
        if (32'(n7) > MAX_POINTS) n_c = NW'(MAX_POINTS);
        else n_c = NW'(n7);
        // Parameter clamp and split.
        t_c = in_t;
        if (t_c > (T_FRAC_BITS+1)'(1) << T_FRAC_BITS)
            t_c = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
        s_c   = SW'(t_c) * SW'(n_c - NW'(1));
        seg_c = NW'(s_c >> T_FRAC_BITS);
        u_c   = {1'b0, s_c[T_FRAC_BITS-1:0]};
        if (seg_c > n_c - NW'(2)) begin
            seg_c = n_c - NW'(2);
            u_c   = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
        end
        i1 = IDX_W'(seg_c);
        i2 = IDX_W'(seg_c + NW'(1));
        i0 = (seg_c == '0) ? '0 : IDX_W'(seg_c - NW'(1));
        i3 = (seg_c + NW'(2) >= n_c) ? i2 : IDX_W'(seg_c + NW'(2));
    end

    assign q_valid = in_valid;
    assign q_data  = {in_coords, IDX_W'(in_index), ld_c, ev_c, u_c, i3, i2, i1, i0};
endmodule
`default_nettype wire

// ----- src/crpe_queue.sv -----
`default_nettype none
// Two-entry queue between the front and the back part.
module crpe_queue #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_data;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- src/crpe_axis.sv -----
`default_nettype none
// One axis: table read, coefficient forming, three Horner steps, halve and saturate.
module crpe_axis #(
    parameter int MAX_POINTS  = crpe_pkg::MaxPointsDefault,
    parameter int T_FRAC_BITS = crpe_pkg::TFracBitsDefault,
    parameter int IDX_W       = $clog2(MAX_POINTS)
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic                    wr_en,
    input  wire logic [IDX_W-1:0]        wr_addr,
    input  wire logic [31:0]             wr_data,
    input  wire logic [4*IDX_W-1:0]      rd_idx,
    input  wire logic [T_FRAC_BITS:0]    u_in,
    output logic [31:0]                  res,
    output logic                         sat
);
    localparam int UW = T_FRAC_BITS + 2;
    localparam int PW = 64;

    // Four copies of the table so that four reads happen in the same cycle.
    logic signed [31:0] tab0 [MAX_POINTS];
    logic signed [31:0] tab1 [MAX_POINTS];
    logic signed [31:0] tab2 [MAX_POINTS];
    logic signed [31:0] tab3 [MAX_POINTS];
    logic signed [31:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [UW-1:0] u1_reg, u2_reg, u3_reg, u4_reg, u5_reg, u6_reg;

    logic signed [39:0] e3_reg, e2_reg, e1_reg, e0_reg;
    logic signed [39:0] e2b_reg, e1b_reg, e0b_reg, e1c_reg, e0c_reg, e0d_reg, e0e_reg;
    logic signed [39:0] e1d_reg, e0f_reg;
    logic signed [PW-1:0] m1_reg, m2_reg, m3_reg;
    logic signed [PW-1:0] a_reg, b_reg;
    logic signed [PW-1:0] a_c, b_c, c_c, r_c;
    logic [31:0] res_reg;
    logic        sat_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tab0[wr_addr] <= wr_data; tab1[wr_addr] <= wr_data;
            tab2[wr_addr] <= wr_data; tab3[wr_addr] <= wr_data;
        end
        if (en) begin
            p0_reg <= tab0[rd_idx[IDX_W-1:0]];
            p1_reg <= tab1[rd_idx[2*IDX_W-1:IDX_W]];
            p2_reg <= tab2[rd_idx[3*IDX_W-1:2*IDX_W]];
            p3_reg <= tab3[rd_idx[4*IDX_W-1:3*IDX_W]];
            u1_reg <= UW'(u_in);
        end
    end

    // Shift the fraction rounding term out of a Horner product.
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] x);
        rnd = (x + (PW'(1) <<< (T_FRAC_BITS-1))) >>> T_FRAC_BITS;
    endfunction

    always_comb begin
        a_c = rnd(m1_reg) + PW'(e2b_reg);
        b_c = rnd(m2_reg) + PW'(e1d_reg);
        c_c = rnd(m3_reg) + PW'(e0f_reg);
        r_c = (c_c + PW'(1)) >>> 1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Coefficients.
            e3_reg <= -40'(p0_reg) + 40'sd3*40'(p1_reg) - 40'sd3*40'(p2_reg) + 40'(p3_reg);
            e2_reg <= 40'sd2*40'(p0_reg) - 40'sd5*40'(p1_reg) + 40'sd4*40'(p2_reg)
                      - 40'(p3_reg);
            e1_reg <= 40'(p2_reg) - 40'(p0_reg);
            e0_reg <= 40'sd2*40'(p1_reg);
            u2_reg <= u1_reg;
            // First Horner step.
            m1_reg  <= PW'(e3_reg) * PW'(u2_reg);
            e2b_reg <= e2_reg; e1b_reg <= e1_reg; e0b_reg <= e0_reg; u3_reg <= u2_reg;
            a_reg   <= a_c; e1c_reg <= e1b_reg; e0c_reg <= e0b_reg; u4_reg <= u3_reg;
            // Second step.
            m2_reg  <= a_reg * PW'(u4_reg); e0d_reg <= e0c_reg; u5_reg <= u4_reg;
            e1d_reg <= e1c_reg;
            b_reg   <= b_c; e0e_reg <= e0d_reg; u6_reg <= u5_reg;
            // Third step, halve and saturate.
            m3_reg  <= b_reg * PW'(u6_reg); e0f_reg <= e0e_reg;
            if (r_c > PW'(32'sh7FFFFFFF)) begin
                res_reg <= 32'h7FFFFFFF; sat_reg <= 1'b1;
            end else if (r_c < -PW'(64'sh80000000)) begin
                res_reg <= 32'h80000000; sat_reg <= 1'b1;
            end else begin
                res_reg <= r_c[31:0]; sat_reg <= 1'b0;
            end
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;
endmodule
`default_nettype wire

// ----- src/crpe_back.sv -----
`default_nettype none
// Back part: writes loads into the tables in order and runs three axis
// pipelines advanced together with a valid chain.
module crpe_back #(
    parameter int MAX_POINTS  = crpe_pkg::MaxPointsDefault,
    parameter int T_FRAC_BITS = crpe_pkg::TFracBitsDefault,
    parameter int IDX_W       = $clog2(MAX_POINTS)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [5*IDX_W+T_FRAC_BITS+98:0] in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [96:0]                     out_data
);
    localparam int DEPTH   = 8;
    localparam int EV_BIT  = 4*IDX_W + T_FRAC_BITS + 1;
    localparam int LD_BIT  = EV_BIT + 1;
    localparam int ADDR_LO = LD_BIT + 1;
    localparam int DATA_LO = ADDR_LO + IDX_W;

    logic [DEPTH-1:0] vld_reg;
    logic             en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [95:0]      wr_data;
    logic [31:0]      rx, ry, rz;
    logic             sx, sy, sz;

    // Pipeline stalls only when the final result is held.
    assign en        = !(vld_reg[DEPTH-1] && !out_ready);
    assign in_ready  = en;
    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = {sx | sy | sz, rz, ry, rx};

    // A load word writes the tables as it leaves the queue.
    assign wr_en   = in_valid && en && in_data[LD_BIT];
    assign wr_addr = in_data[DATA_LO-1:ADDR_LO];
    assign wr_data = in_data[DATA_LO+95:DATA_LO];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], in_valid && in_data[EV_BIT]};
    end

    crpe_axis #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_x (
        .aclk(aclk), .en(en), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data[31:0]),
        .rd_idx(in_data[4*IDX_W-1:0]), .u_in(in_data[4*IDX_W+T_FRAC_BITS:4*IDX_W]),
        .res(rx), .sat(sx));
    crpe_axis #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_y (
        .aclk(aclk), .en(en), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data[63:32]),
        .rd_idx(in_data[4*IDX_W-1:0]), .u_in(in_data[4*IDX_W+T_FRAC_BITS:4*IDX_W]),
        .res(ry), .sat(sy));
    crpe_axis #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_z (
        .aclk(aclk), .en(en), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data[95:64]),
        .rd_idx(in_data[4*IDX_W-1:0]), .u_in(in_data[4*IDX_W+T_FRAC_BITS:4*IDX_W]),
        .res(rz), .sat(sz));
endmodule
`default_nettype wire

// ----- src/catmull_rom_path_eval.sv -----
`default_nettype none
// Channel  | Direction | Payload
// s_axis   | in        | tdata: cmd, point_index, coord_x, coord_y, coord_z, t_pos
// m_axis   | out       | tdata: pos_x, pos_y, pos_z, sat_flag
// apb      | in        | register 0 num_points at byte address 0
// One word is accepted per cycle while m_tready does not hold the output; an evaluation
// passes from the queue through the table read, the coefficient stage, three
// multiply-and-round Horner steps per axis and the halve-and-saturate register.
// Loads are written into the tables as they leave the queue, in order with evaluations.
// Reset clears the valid chain, the queue and num_points (to 4); tables stay undefined.
// A stall on m_tready freezes the back pipeline; the queue absorbs two words.
module catmull_rom_path_eval #(
    parameter int MAX_POINTS  = crpe_pkg::MaxPointsDefault,
    parameter int T_FRAC_BITS = crpe_pkg::TFracBitsDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[0], point_index[6:1], coord_x[38:7], coord_y[70:39], coord_z[102:71],
    // t_pos[T_FRAC_BITS+103:103], zero fill
    input  wire logic [((T_FRAC_BITS+104+7)/8)*8-1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], sat_flag[96], zero fill
    output logic [103:0]     m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [crpe_pkg::CfgAddrW-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int QW    = 5*IDX_W + T_FRAC_BITS + 99;

    logic [6:0]   num_points_reg;
    logic         fq_valid, fq_ready, qb_valid, qb_ready;
    logic [QW-1:0] fq_data, qb_data;
    logic [96:0]  res;

    // Configuration register.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) num_points_reg <= crpe_pkg::NumPointsReset;
        else if (psel && penable && pwrite && pready && paddr == crpe_pkg::RegNumPoints)
            num_points_reg <= pwdata[6:0];
    end
    assign prdata = (paddr == crpe_pkg::RegNumPoints) ? {25'd0, num_points_reg} : 32'd0;

    crpe_front #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_front (
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[0]), .in_index(s_tdata[6:1]), .in_coords(s_tdata[102:7]),
        .in_t(s_tdata[T_FRAC_BITS+103:103]), .num_points(num_points_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));

    crpe_queue #(.W(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_valid(fq_valid), .in_ready(fq_ready),
        .in_data(fq_data), .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data));

    crpe_back #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_back (
        .aclk(aclk), .aresetn(aresetn), .in_valid(qb_valid), .in_ready(qb_ready),
        .in_data(qb_data), .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res));

    assign m_tdata = {7'd0, res};
endmodule
`default_nettype wire

// ----- tb/path_checker.sv -----
`timescale 1ns / 1ps
module path_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [119:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [103:0] m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output int                fail_count,
    output int                pending
);
    localparam longint OneT = 64'sd65536;

    typedef struct packed {
        logic        sat;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } position_t;

    longint tab_x[64];
    longint tab_y[64];
    longint tab_z[64];
    logic [6:0] point_count;
    position_t positions_due[$];
    int positions_seen;

    // Product with the fraction, rounded with halves going up.
    function automatic longint frac_mul(longint a, longint u);
        return (a * u + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [31:0] spline_axis(longint p0, longint p1, longint p2,
                                                longint p3, longint u, ref logic sat);
        longint e3, e2, e1, e0, acc;
        e3 = -p0 + 3 * p1 - 3 * p2 + p3;
        e2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        e1 = p2 - p0;
        e0 = 2 * p1;
        acc = frac_mul(e3, u) + e2;
        acc = frac_mul(acc, u) + e1;
        acc = frac_mul(acc, u) + e0;
        acc = (acc + 1) >>> 1;
        if (acc > 64'sh7FFFFFFF) begin
            acc = 64'sh7FFFFFFF;
            sat = 1'b1;
        end
        if (acc < -64'sh80000000) begin
            acc = -64'sh80000000;
            sat = 1'b1;
        end
        return acc[31:0];
    endfunction

    function automatic position_t predict_position(logic [16:0] t_raw);
        position_t r;
        longint n, t, s, seg, u;
        int i0, i1, i2, i3;
        logic sat;
        sat = 1'b0;
        n = point_count;
        if (n < 4) n = 4;
        if (n > 64) n = 64;
        t = t_raw;
        if (t > OneT) t = OneT;
        s = t * (n - 1);
        seg = s >>> 16;
        u = s & (OneT - 1);
        if (seg > n - 2) begin
            seg = n - 2;
            u = OneT;
        end
        i1 = int'(seg);
        i2 = i1 + 1;
        i0 = (i1 == 0) ? 0 : i1 - 1;
        i3 = (i1 + 2 >= n) ? i2 : i1 + 2;
        r.x = spline_axis(tab_x[i0], tab_x[i1], tab_x[i2], tab_x[i3], u, sat);
        r.y = spline_axis(tab_y[i0], tab_y[i1], tab_y[i2], tab_y[i3], u, sat);
        r.z = spline_axis(tab_z[i0], tab_z[i1], tab_z[i2], tab_z[i3], u, sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h",
                 positions_seen, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        positions_seen = 0;
        point_count = crpe_pkg::NumPointsReset;
    end

    // Track register writes, loads and evaluations; compare each result word.
    always @(posedge aclk) begin
        position_t want;
        if (!aresetn) begin
            point_count <= crpe_pkg::NumPointsReset;
        end else begin
            if (psel && penable && pwrite && paddr == crpe_pkg::RegNumPoints)
                point_count <= pwdata[6:0];
            if (s_tvalid && s_tready) begin
                if (s_tdata[0] == crpe_pkg::CmdLoad) begin
                    tab_x[s_tdata[6:1]] = longint'($signed(s_tdata[38:7]));
                    tab_y[s_tdata[6:1]] = longint'($signed(s_tdata[70:39]));
                    tab_z[s_tdata[6:1]] = longint'($signed(s_tdata[102:71]));
                end else begin
                    positions_due.push_back(predict_position(s_tdata[119:103]));
                end
            end
            if (m_tvalid && m_tready) begin
                if (positions_due.size() == 0) begin
                    report_mismatch("unexpected word x", m_tdata[31:0], 32'd0);
                end else begin
                    want = positions_due.pop_front();
                    if (m_tdata[31:0] !== want.x) report_mismatch("x", m_tdata[31:0], want.x);
                    if (m_tdata[63:32] !== want.y)
                        report_mismatch("y", m_tdata[63:32], want.y);
                    if (m_tdata[95:64] !== want.z)
                        report_mismatch("z", m_tdata[95:64], want.z);
                    if (m_tdata[96] !== want.sat)
                        report_mismatch("sat", {31'd0, m_tdata[96]}, {31'd0, want.sat});
                end
                positions_seen++;
            end
            pending = positions_due.size();
        end
    end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [119:0] s_tdata = '0;   // cmd, point_index, coord_x, coord_y, coord_z, t_pos
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [103:0] m_tdata;        // pos_x, pos_y, pos_z, sat_flag
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count, pending;
    int send_idle_pct, recv_idle_pct;
    int evals_sent;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    catmull_rom_path_eval u_top (.*);

    path_checker u_check (.*);

    initial begin
        #50_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Receiver stalls at the chosen rate.
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic write_point_count(logic [6:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= crpe_pkg::RegNumPoints; pwdata <= {25'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Present one word, with a random gap first, and hold it until taken.
    task automatic send_word(logic cmd, logic [5:0] idx, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [16:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t, cz, cy, cx, idx, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (cmd == crpe_pkg::CmdEval) evals_sent++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] rand_t();
        case ($urandom_range(7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'(17'd65536 + $urandom_range(1, 65535));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    initial begin
        int sizes[4] = '{4, 64, 7, 33};
        evals_sent = 0;
        send_idle_pct = 14;
        recv_idle_pct = 48;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: fill the whole table, then the ends and clamping cases.
        for (int i = 0; i < 64; i++)
            send_word(crpe_pkg::CmdLoad, i[5:0], rand_coord(), rand_coord(), rand_coord(),
                      17'($urandom));
        send_word(crpe_pkg::CmdLoad, 6'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                  17'h1FFFF);
        send_word(crpe_pkg::CmdLoad, 6'd1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 17'd0);
        send_word(crpe_pkg::CmdLoad, 6'd2, 32'h7FFFFFFF, 32'h80000000, 32'd0, 17'd0);
        send_word(crpe_pkg::CmdLoad, 6'd3, 32'h80000000, 32'h7FFFFFFF, 32'd5, 17'd0);
        foreach (sizes[k]) begin
            drain();
            write_point_count(sizes[k][6:0]);
            send_word(crpe_pkg::CmdEval, 6'($urandom), $urandom, $urandom, $urandom, 17'd0);
            send_word(crpe_pkg::CmdEval, 6'($urandom), $urandom, $urandom, $urandom,
                      17'd65536);
            send_word(crpe_pkg::CmdEval, 6'($urandom), $urandom, $urandom, $urandom,
                      17'h1FFFF);
            send_word(crpe_pkg::CmdEval, 6'($urandom), $urandom, $urandom, $urandom,
                      17'd32768);
            send_word(crpe_pkg::CmdEval, 6'($urandom), $urandom, $urandom, $urandom,
                      17'd65535);
        end

        // Random phases with changing point counts and idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            if (ph == 2) begin
                send_idle_pct = 48;
                recv_idle_pct = 14;
            end
            if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_point_count((ph % 3 == 0) ? 7'd64 : 7'($urandom_range(4, 64)));
            for (int i = 0; i < 115; i++) begin
                if ($urandom_range(3) == 0)
                    send_word(crpe_pkg::CmdLoad, 6'($urandom), rand_coord(), rand_coord(),
                              rand_coord(), 17'($urandom));
                else
                    send_word(crpe_pkg::CmdEval, 6'($urandom), $urandom, $urandom,
                              $urandom, rand_t());
            end
        end
        drain();

        $display("Covered %0d evaluations over point counts 4 to 64, with loads between.",
                 evals_sent);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
